### rtl/core/closed_catmull_rom_evaluator_macros.svh
// Assertion helpers shared by the evaluator.
`ifndef CLOSED_CATMULL_ROM_EVALUATOR_MACROS_SVH
`define CLOSED_CATMULL_ROM_EVALUATOR_MACROS_SVH

// Overlapping implication, checked on the rising clock edge outside reset.
`define CCR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CCR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ccr_pkg.sv
package ccr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 32;
  localparam int T_W        = 16;
  localparam int SCALED_W   = T_W + COUNT_W;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = ACC_W + T_W + 1;
  localparam int NUM_TAPS   = 4;
  localparam int NUM_STEPS  = 3;
  localparam int CNT_W      = 2;

  localparam logic [CNT_W-1:0] LAST_TAP  = CNT_W'(NUM_TAPS - 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_STEPS - 1);

  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [T_W-1:0]            global_t;
  } ccr_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tan_x;
    logic signed [COORD_W-1:0] tan_y;
    logic signed [COORD_W-1:0] tan_z;
    logic                      ok;
  } ccr_res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } ccr_point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_COEF,
    ST_STEP,
    ST_FIN,
    ST_DONE
  } ccr_state_e;

  typedef enum logic [CNT_W-1:0] {
    STEP_A1,
    STEP_A2,
    STEP_A3
  } ccr_step_e;

  typedef struct packed {
    logic      shift;
    logic      coef;
    logic      step;
    logic      fin;
    ccr_step_e sel;
  } ccr_lane_ctl_t;

endpackage

### rtl/core/ccr_store.sv
module ccr_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ccr_pkg::ADDR_W-1:0] addr_i,
  input  ccr_pkg::ccr_point_t        wdata_i,
  output ccr_pkg::ccr_point_t        rdata_o
);

  ccr_pkg::ccr_point_t mem_q [ccr_pkg::MAX_POINTS];
  ccr_pkg::ccr_point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ccr_lane.sv
module ccr_lane (
  input  logic                               clk_i,
  input  logic signed [ccr_pkg::COORD_W-1:0] pt_i,
  input  logic [ccr_pkg::T_W-1:0]            t_i,
  input  ccr_pkg::ccr_lane_ctl_t             ctl_i,
  output logic signed [ccr_pkg::COORD_W-1:0] pos_o,
  output logic signed [ccr_pkg::COORD_W-1:0] tan_o
);

  localparam logic signed [ccr_pkg::PROD_W-1:0] RndHalf =
    ccr_pkg::PROD_W'(64'sd1 <<< (ccr_pkg::T_W - 1));
  localparam logic signed [ccr_pkg::ACC_W-1:0] AccOne = ccr_pkg::ACC_W'(64'sd1);
  localparam logic signed [ccr_pkg::ACC_W-1:0] SatMax = ccr_pkg::ACC_W'(64'sd2147483647);
  localparam logic signed [ccr_pkg::ACC_W-1:0] SatMin = ccr_pkg::ACC_W'(-64'sd2147483648);

  logic signed [ccr_pkg::COORD_W-1:0] tap_q [ccr_pkg::NUM_TAPS];
  logic signed [ccr_pkg::ACC_W-1:0]   e0, e1, e2, e3;
  logic signed [ccr_pkg::ACC_W-1:0]   a0, a1, a2, a3;
  logic signed [ccr_pkg::ACC_W-1:0]   a1_q, a2_q, a3_q;
  logic signed [ccr_pkg::ACC_W-1:0]   h_q, d_q;
  logic signed [ccr_pkg::ACC_W-1:0]   add_h, add_d;
  logic                               upd_d;
  logic signed [ccr_pkg::T_W:0]       t_s;
  logic signed [ccr_pkg::PROD_W-1:0]  prod_h, prod_d;
  logic signed [ccr_pkg::PROD_W-1:0]  rnd_h, rnd_d;
  logic signed [ccr_pkg::COORD_W-1:0] pos_q, tan_q;

  function automatic logic signed [ccr_pkg::COORD_W-1:0] sat_half(
    input logic signed [ccr_pkg::ACC_W-1:0] x
  );
    logic signed [ccr_pkg::ACC_W-1:0] hv;
    hv = (x + AccOne) >>> 1;
    if (hv > SatMax) begin
      hv = SatMax;
    end else if (hv < SatMin) begin
      hv = SatMin;
    end
    return $signed(hv[ccr_pkg::COORD_W-1:0]);
  endfunction

  assign e0 = ccr_pkg::ACC_W'(tap_q[0]);
  assign e1 = ccr_pkg::ACC_W'(tap_q[1]);
  assign e2 = ccr_pkg::ACC_W'(tap_q[2]);
  assign e3 = ccr_pkg::ACC_W'(tap_q[3]);

  // Doubled basis coefficients of the uniform segment.
  assign a0 = (e3 - e0) + (e1 + (e1 <<< 1)) - (e2 + (e2 <<< 1));
  assign a1 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign a2 = e2 - e0;
  assign a3 = e1 <<< 1;

  assign t_s    = $signed({1'b0, t_i});
  assign prod_h = h_q * t_s;
  assign prod_d = d_q * t_s;
  assign rnd_h  = (prod_h + RndHalf) >>> ccr_pkg::T_W;
  assign rnd_d  = (prod_d + RndHalf) >>> ccr_pkg::T_W;

  always_comb begin
    add_h = a3_q;
    add_d = a2_q;
    upd_d = 1'b0;
    case (ctl_i.sel)
      ccr_pkg::STEP_A1: begin
        add_h = a1_q;
        add_d = a1_q <<< 1;
        upd_d = 1'b1;
      end
      ccr_pkg::STEP_A2: begin
        add_h = a2_q;
        add_d = a2_q;
        upd_d = 1'b1;
      end
      ccr_pkg::STEP_A3: begin
        add_h = a3_q;
      end
      default: begin
        add_h = a3_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      tap_q[0] <= tap_q[1];
      tap_q[1] <= tap_q[2];
      tap_q[2] <= tap_q[3];
      tap_q[3] <= pt_i;
    end
    if (ctl_i.coef) begin
      a1_q <= a1;
      a2_q <= a2;
      a3_q <= a3;
      h_q  <= a0;
      d_q  <= a0 + (a0 <<< 1);
    end
    if (ctl_i.step) begin
      h_q <= $signed(rnd_h[ccr_pkg::ACC_W-1:0]) + add_h;
      if (upd_d) begin
        d_q <= $signed(rnd_d[ccr_pkg::ACC_W-1:0]) + add_d;
      end
    end
    if (ctl_i.fin) begin
      pos_q <= sat_half(h_q);
      tan_q <= sat_half(d_q);
    end
  end

  assign pos_o = pos_q;
  assign tan_o = tan_q;

endmodule

### rtl/core/closed_catmull_rom_evaluator.sv
// Closed-loop Catmull-Rom curve evaluator.
// A request is taken on the rising edge where start is high and busy is low.
// With mode low the request appends its point to the loop store; ok is low
// when the store already holds all of its points. With mode high the request
// evaluates the curve at global_t and returns position and tangent.
// Each result is shown on res_o for one cycle while valid_o is high; the
// receiver cannot stall it, so a result must be taken when it appears.
// An append, or an evaluation on an empty store, answers in the next cycle
// and busy stays low, so such requests may follow every cycle.
// An evaluation holds busy until its result appears. It forms the first
// read index from the segment, reads the four neighbor points through the
// single store port, forms the coefficients, runs the three Horner steps
// in each of the three axis lanes, saturates and merges the lanes.
// Reset empties the store by clearing the point count and returns to idle.
`include "closed_catmull_rom_evaluator_macros.svh"

module closed_catmull_rom_evaluator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ccr_pkg::ccr_req_t req_i,
  output logic              valid_o,
  output ccr_pkg::ccr_res_t res_o
);

  ccr_pkg::ccr_state_e              state_q, state_d;
  logic [ccr_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [ccr_pkg::COUNT_W-1:0]      count_q, count_d;
  logic [ccr_pkg::ADDR_W-1:0]       idx_q, idx_d;
  logic [ccr_pkg::SCALED_W-1:0]     scaled_q, scaled_d;
  logic                             valid_q, valid_d;
  ccr_pkg::ccr_res_t                res_q, res_d;

  logic                             accept;
  logic                             full;
  logic [ccr_pkg::ADDR_W-1:0]       seg;
  logic [ccr_pkg::ADDR_W-1:0]       idx_first;
  logic [ccr_pkg::ADDR_W-1:0]       idx_next;
  logic [ccr_pkg::COUNT_W-1:0]      idx_inc;
  logic [ccr_pkg::COUNT_W-1:0]      count_dec;
  logic                             mem_we;
  logic [ccr_pkg::ADDR_W-1:0]       mem_addr;
  ccr_pkg::ccr_point_t              wpoint;
  ccr_pkg::ccr_point_t              rpoint;
  ccr_pkg::ccr_lane_ctl_t           ctl;
  logic signed [ccr_pkg::COORD_W-1:0] pos_x, pos_y, pos_z;
  logic signed [ccr_pkg::COORD_W-1:0] tan_x, tan_y, tan_z;

  assign busy   = (state_q != ccr_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count_q == ccr_pkg::COUNT_W'(ccr_pkg::MAX_POINTS));

  assign seg       = scaled_q[ccr_pkg::T_W +: ccr_pkg::ADDR_W];
  assign count_dec = count_q - ccr_pkg::COUNT_W'(1);
  assign idx_first = (seg == '0) ? count_dec[ccr_pkg::ADDR_W-1:0] :
                                   seg - ccr_pkg::ADDR_W'(1);
  assign idx_inc   = ccr_pkg::COUNT_W'(idx_q) + ccr_pkg::COUNT_W'(1);
  assign idx_next  = (idx_inc == count_q) ? '0 : idx_inc[ccr_pkg::ADDR_W-1:0];

  assign wpoint.x = req_i.point_x;
  assign wpoint.y = req_i.point_y;
  assign wpoint.z = req_i.point_z;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    count_d  = count_q;
    idx_d    = idx_q;
    scaled_d = scaled_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    ctl      = '0;
    mem_we   = 1'b0;
    mem_addr = count_q[ccr_pkg::ADDR_W-1:0];
    case (state_q)
      ccr_pkg::ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          valid_d = 1'b1;
          if (!req_i.mode) begin
            if (!full) begin
              mem_we   = 1'b1;
              count_d  = count_q + ccr_pkg::COUNT_W'(1);
              res_d.ok = 1'b1;
            end
          end else if (count_q != '0) begin
            valid_d  = 1'b0;
            scaled_d = ccr_pkg::SCALED_W'(req_i.global_t) *
                       ccr_pkg::SCALED_W'(count_q);
            state_d  = ccr_pkg::ST_ADDR;
          end
        end
      end
      ccr_pkg::ST_ADDR: begin
        mem_addr = idx_first;
        idx_d    = idx_first;
        cnt_d    = '0;
        state_d  = ccr_pkg::ST_READ;
      end
      ccr_pkg::ST_READ: begin
        mem_addr  = idx_next;
        idx_d     = idx_next;
        ctl.shift = 1'b1;
        cnt_d     = cnt_q + ccr_pkg::CNT_W'(1);
        if (cnt_q == ccr_pkg::LAST_TAP) begin
          cnt_d   = '0;
          state_d = ccr_pkg::ST_COEF;
        end
      end
      ccr_pkg::ST_COEF: begin
        ctl.coef = 1'b1;
        cnt_d    = '0;
        state_d  = ccr_pkg::ST_STEP;
      end
      ccr_pkg::ST_STEP: begin
        ctl.step = 1'b1;
        ctl.sel  = ccr_pkg::ccr_step_e'(cnt_q);
        cnt_d    = cnt_q + ccr_pkg::CNT_W'(1);
        if (cnt_q == ccr_pkg::LAST_STEP) begin
          cnt_d   = '0;
          state_d = ccr_pkg::ST_FIN;
        end
      end
      ccr_pkg::ST_FIN: begin
        ctl.fin = 1'b1;
        state_d = ccr_pkg::ST_DONE;
      end
      ccr_pkg::ST_DONE: begin
        res_d.pos_x = pos_x;
        res_d.pos_y = pos_y;
        res_d.pos_z = pos_z;
        res_d.tan_x = tan_x;
        res_d.tan_y = tan_y;
        res_d.tan_z = tan_z;
        res_d.ok    = 1'b1;
        valid_d     = 1'b1;
        state_d     = ccr_pkg::ST_IDLE;
      end
      default: begin
        state_d = ccr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccr_pkg::ST_IDLE;
      cnt_q   <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    scaled_q <= scaled_d;
    res_q    <= res_d;
  end

  ccr_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (wpoint),
    .rdata_o (rpoint)
  );

  ccr_lane u_lane_x (
    .clk_i (clk_i),
    .pt_i  (rpoint.x),
    .t_i   (scaled_q[ccr_pkg::T_W-1:0]),
    .ctl_i (ctl),
    .pos_o (pos_x),
    .tan_o (tan_x)
  );

  ccr_lane u_lane_y (
    .clk_i (clk_i),
    .pt_i  (rpoint.y),
    .t_i   (scaled_q[ccr_pkg::T_W-1:0]),
    .ctl_i (ctl),
    .pos_o (pos_y),
    .tan_o (tan_y)
  );

  ccr_lane u_lane_z (
    .clk_i (clk_i),
    .pt_i  (rpoint.z),
    .t_i   (scaled_q[ccr_pkg::T_W-1:0]),
    .ctl_i (ctl),
    .pos_o (pos_z),
    .tan_o (tan_z)
  );

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `CCR_ASSERT_NXT(a_eval_goes_busy, accept && req_i.mode && (count_q != '0), busy, "evaluation did not start")
  `CCR_ASSERT_NXT(a_full_holds_count, accept && !req_i.mode && full, $stable(count_q), "append changed a full store")
  `CCR_ASSERT_NXT(a_done_delivers, state_q == ccr_pkg::ST_DONE, valid_o && res_o.ok, "evaluation result lost")
  `CCR_ASSERT_IMP(a_fail_is_zero, valid_o && !res_o.ok, (res_o.pos_x == '0) && (res_o.tan_z == '0), "failed request has nonzero data")

endmodule
